### sv/iasc_pkg.sv
// ----------------------------------------------------------------------------
// iasc_pkg: shared types and arithmetic for the adaptive step controller
// Step and counter widths, the register map, the configuration and state
// records, and the saturating Q.16 step scaling.
// ----------------------------------------------------------------------------
package iasc_pkg;

	localparam int STEP_W   = 32;
	localparam int COUNT_W  = 16;
	localparam int ITER_W   = 16;
	localparam int RED_W    = 17;
	localparam int RAISE_W  = 24;
	localparam int FRAC_W   = 16;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = STEP_W + RAISE_W;
	localparam int SCALED_W = PROD_W - FRAC_W;

	localparam logic [IDX_W-1:0] REG_REDUCTION_FACTOR = 3'd0;
	localparam logic [IDX_W-1:0] REG_RAISE_FACTOR     = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEPS_BEFORE_RED = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEPS_BEFORE_RSE = 3'd3;
	localparam logic [IDX_W-1:0] REG_MIN_ITERS        = 3'd4;
	localparam logic [IDX_W-1:0] REG_MAX_ITERS        = 3'd5;
	localparam logic [IDX_W-1:0] REG_MIN_STEP         = 3'd6;
	localparam logic [IDX_W-1:0] REG_INITIAL_STEP     = 3'd7;

	localparam logic [RED_W-1:0]   RST_REDUCTION_FACTOR = RED_W'(32768);
	localparam logic [RAISE_W-1:0] RST_RAISE_FACTOR     = RAISE_W'(131072);
	localparam logic [COUNT_W-1:0] RST_STEPS_BEFORE     = COUNT_W'(1);
	localparam logic [ITER_W-1:0]  RST_MIN_ITERS        = ITER_W'(1);
	localparam logic [ITER_W-1:0]  RST_MAX_ITERS        = ITER_W'(0);
	localparam logic [STEP_W-1:0]  RST_MIN_STEP         = STEP_W'(1);
	localparam logic [STEP_W-1:0]  RST_INITIAL_STEP     = STEP_W'(65536);

	typedef struct packed {
		logic [RED_W-1:0]   reduction_factor;
		logic [RAISE_W-1:0] raise_factor;
		logic [COUNT_W-1:0] steps_before_reduction;
		logic [COUNT_W-1:0] steps_before_raise;
		logic [ITER_W-1:0]  min_iters;
		logic [ITER_W-1:0]  max_iters;
		logic [STEP_W-1:0]  min_step;
	} cfg_t;

	typedef struct packed {
		logic [STEP_W-1:0]  current_step;
		logic               last_chance;
		logic [COUNT_W-1:0] steps_since_reduction;
		logic [COUNT_W-1:0] steps_since_raise;
	} state_t;

	// Step times a Q.16 factor, truncated, saturated to the step width.
	function automatic logic [STEP_W-1:0] scale_step(input logic [STEP_W-1:0] step,
		input logic [RAISE_W-1:0] factor);
		logic [PROD_W-1:0]   prod;
		logic [SCALED_W-1:0] scaled;
		prod   = PROD_W'(step) * PROD_W'(factor);
		scaled = prod[PROD_W-1:FRAC_W];
		if (|scaled[SCALED_W-1:STEP_W]) begin
			return '1;
		end
		return scaled[STEP_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
		return (c == '1) ? c : c + COUNT_W'(1);
	endfunction

endpackage

### sv/iasc_decide.sv
// ----------------------------------------------------------------------------
// iasc_decide: next-step decision logic
// Takes the registered state, the configuration and one item and forms the
// next state; the new step of the result is the next current step.
// ----------------------------------------------------------------------------
module iasc_decide import iasc_pkg::*; (
	input  cfg_t               cfg,
	input  state_t             state,
	input  logic               func,
	input  logic [ITER_W-1:0]  performed_iters,
	input  logic [STEP_W-1:0]  max_step,
	output state_t             next_state
);

	logic [STEP_W-1:0]  shrunk;
	logic [STEP_W-1:0]  raised;
	logic [STEP_W-1:0]  shrunk_ceil;
	logic [STEP_W-1:0]  floored;
	logic [STEP_W-1:0]  raised_ceil;
	logic [COUNT_W-1:0] inc_red;
	logic [COUNT_W-1:0] inc_rse;
	logic               may_raise;

	// The two products run side by side from the state register.
	assign shrunk = scale_step(state.current_step, RAISE_W'(cfg.reduction_factor));
	assign raised = scale_step(state.current_step, cfg.raise_factor);

	assign shrunk_ceil = (shrunk < max_step) ? shrunk : max_step;
	assign floored     = (shrunk > cfg.min_step) ? shrunk : cfg.min_step;
	assign raised_ceil = (raised < max_step) ? raised : max_step;

	assign inc_red = count_up(state.steps_since_reduction);
	assign inc_rse = count_up(state.steps_since_raise);

	assign may_raise = (performed_iters <= cfg.min_iters)
		&& (inc_red > cfg.steps_before_reduction)
		&& (inc_rse > cfg.steps_before_raise)
		&& (state.current_step < max_step);

	always_comb begin
		next_state = state;
		if (func) begin
			priority if (shrunk > cfg.min_step) begin
				next_state.last_chance           = 1'b0;
				next_state.steps_since_reduction = '0;
				next_state.current_step          = shrunk_ceil;
			end else if (!state.last_chance) begin
				// First time at the floor: fall back to it unclamped.
				next_state.last_chance  = 1'b1;
				next_state.current_step = cfg.min_step;
			end else begin
				next_state.current_step = shrunk_ceil;
			end
		end else begin
			next_state.steps_since_reduction = inc_red;
			next_state.steps_since_raise     = inc_rse;
			priority if (performed_iters > cfg.max_iters) begin
				next_state.steps_since_reduction = '0;
				next_state.last_chance           = 1'b0;
				next_state.current_step = (floored < max_step) ? floored : max_step;
			end else if (may_raise) begin
				next_state.steps_since_raise = '0;
				next_state.current_step      = raised_ceil;
			end else begin
				next_state.current_step = state.current_step;
			end
		end
	end

endmodule

### sv/iteration_adaptive_step_control.sv
// ----------------------------------------------------------------------------
// iteration_adaptive_step_control: adaptive solver step-size controller
// Input stage, then output register; one item per cycle sustained with
// no output stall, set by the current-step loop through both products.
// Reset loads register defaults, current step 65536, counters and flag zero.
// ----------------------------------------------------------------------------
module iteration_adaptive_step_control import iasc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // performed_iters[15:0], max_step[47:16]
	input  logic              s_tuser,   // func[0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata    // new_step[31:0]
);

	cfg_t               cfg_q;
	state_t             state_q;
	state_t             next_state;

	logic               valid_s1;
	logic               func_s1;
	logic [ITER_W-1:0]  iters_s1;
	logic [STEP_W-1:0]  max_step_s1;
	logic               out_valid_q;
	logic [STEP_W-1:0]  out_step_q;
	logic               advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reduction_factor       <= RST_REDUCTION_FACTOR;
			cfg_q.raise_factor           <= RST_RAISE_FACTOR;
			cfg_q.steps_before_reduction <= RST_STEPS_BEFORE;
			cfg_q.steps_before_raise     <= RST_STEPS_BEFORE;
			cfg_q.min_iters              <= RST_MIN_ITERS;
			cfg_q.max_iters              <= RST_MAX_ITERS;
			cfg_q.min_step               <= RST_MIN_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REDUCTION_FACTOR: cfg_q.reduction_factor <= cfg_data[RED_W-1:0];
				REG_RAISE_FACTOR:     cfg_q.raise_factor <= cfg_data[RAISE_W-1:0];
				REG_STEPS_BEFORE_RED: cfg_q.steps_before_reduction <= cfg_data[COUNT_W-1:0];
				REG_STEPS_BEFORE_RSE: cfg_q.steps_before_raise <= cfg_data[COUNT_W-1:0];
				REG_MIN_ITERS:        cfg_q.min_iters <= cfg_data[ITER_W-1:0];
				REG_MAX_ITERS:        cfg_q.max_iters <= cfg_data[ITER_W-1:0];
				REG_MIN_STEP:         cfg_q.min_step <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The initial step register only ever feeds the current step, so a write
	// to it goes straight into the state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.current_step          <= RST_INITIAL_STEP;
			state_q.last_chance           <= 1'b0;
			state_q.steps_since_reduction <= '0;
			state_q.steps_since_raise     <= '0;
		end else if (cfg_we && cfg_index == REG_INITIAL_STEP) begin
			state_q.current_step <= cfg_data[STEP_W-1:0];
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1     <= s_tuser;
			iters_s1    <= s_tdata[ITER_W-1:0];
			max_step_s1 <= s_tdata[ITER_W+STEP_W-1:ITER_W];
		end
		if (advance) begin
			out_step_q <= next_state.current_step;
		end
	end

	iasc_decide u_decide (
		.cfg             (cfg_q),
		.state           (state_q),
		.func            (func_s1),
		.performed_iters (iters_s1),
		.max_step        (max_step_s1),
		.next_state      (next_state)
	);

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stage empty but not ready");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed item produced no result");

	a_result_is_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tdata == state_q.current_step))
		else $error("result step differs from the updated current step");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && valid_s1) |-> !s_tready)
		else $error("input accepted while both stages are full and stalled");
`endif

endmodule

### sim/iteration_adaptive_step_control_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iteration_adaptive_step_control_test: self-checking bench for the step controller
// Drives solver events into the stream input and keeps its own model of the
// step, the last-chance flag and the hold-off counters. Each result item is
// compared with the oldest predicted step. Covers the reset settings, the
// floor fallback, factor and product extremes, the hold-off counters, random
// traffic under several idling patterns and a long output stall.
// ----------------------------------------------------------------------------
module iteration_adaptive_step_control_test;
	import iasc_pkg::*;

	localparam int CLOCK_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 4;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data  = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata   = '0;   // performed_iters[15:0], max_step[47:16]
	logic              s_tuser   = 1'b0; // func[0]
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;          // new_step[31:0]

	// Local copy of the controller's registers and state.
	logic [RED_W-1:0]   ctl_reduce;
	logic [RAISE_W-1:0] ctl_raise;
	logic [COUNT_W-1:0] ctl_hold_reduce;
	logic [COUNT_W-1:0] ctl_hold_raise;
	logic [ITER_W-1:0]  ctl_low_iters;
	logic [ITER_W-1:0]  ctl_high_iters;
	logic [STEP_W-1:0]  ctl_floor;
	logic [STEP_W-1:0]  ctl_step;
	logic               ctl_last_chance;
	logic [COUNT_W-1:0] ctl_since_reduce;
	logic [COUNT_W-1:0] ctl_since_raise;

	logic [STEP_W-1:0] expected_steps[$];

	int fail_count    = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int hold_left     = 0;
	int cycle_count   = 0;

	iteration_adaptive_step_control dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CLOCK_LIMIT) begin
			$display("%0t ns: timeout with %0d results outstanding", $time,
				expected_steps.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Output side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		logic [STEP_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_steps.size() == 0) begin
				fail_count++;
				$display("%0t ns: unexpected new_step, expected none, actual %h",
					$time, m_tdata);
			end else begin
				want = expected_steps.pop_front();
				if (m_tdata !== want) begin
					fail_count++;
					$display("%0t ns: new_step mismatch, expected %h, actual %h",
						$time, want, m_tdata);
				end
			end
		end
	end

	// Step times a Q.16 factor: truncate the fraction, saturate to the step width.
	function automatic logic [STEP_W-1:0] q16_scale(input logic [STEP_W-1:0] step,
		input logic [RAISE_W-1:0] factor);
		logic [STEP_W+RAISE_W-1:0] product;
		product = {{RAISE_W{1'b0}}, step} * {{STEP_W{1'b0}}, factor};
		if (|product[STEP_W+RAISE_W-1:STEP_W+16]) begin
			return '1;
		end
		return product[STEP_W+15:16];
	endfunction

	function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] c);
		return (&c) ? c : c + COUNT_W'(1);
	endfunction

	function automatic logic [STEP_W-1:0] lower_of(input logic [STEP_W-1:0] a,
		input logic [STEP_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [31:0] pick_one(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		case ($urandom_range(3))
			0: return a;
			1: return b;
			2: return c;
			default: return d;
		endcase
	endfunction

	task automatic reset_controller_model();
		ctl_reduce       = RST_REDUCTION_FACTOR;
		ctl_raise        = RST_RAISE_FACTOR;
		ctl_hold_reduce  = RST_STEPS_BEFORE;
		ctl_hold_raise   = RST_STEPS_BEFORE;
		ctl_low_iters    = RST_MIN_ITERS;
		ctl_high_iters   = RST_MAX_ITERS;
		ctl_floor        = RST_MIN_STEP;
		ctl_step         = RST_INITIAL_STEP;
		ctl_last_chance  = 1'b0;
		ctl_since_reduce = '0;
		ctl_since_raise  = '0;
	endtask

	// Applies one solver event to the model and returns the chosen step.
	task automatic advance_controller(input logic redo, input logic [ITER_W-1:0] iters,
		input logic [STEP_W-1:0] ceiling, output logic [STEP_W-1:0] chosen);
		logic [STEP_W-1:0] shrunk;
		shrunk = q16_scale(ctl_step, RAISE_W'(ctl_reduce));
		if (redo) begin
			if (shrunk > ctl_floor) begin
				ctl_last_chance  = 1'b0;
				ctl_since_reduce = '0;
				ctl_step         = lower_of(shrunk, ceiling);
			end else if (!ctl_last_chance) begin
				// First fall back to the floor, which is not clamped to the ceiling.
				ctl_last_chance = 1'b1;
				ctl_step        = ctl_floor;
			end else begin
				ctl_step = lower_of(shrunk, ceiling);
			end
		end else begin
			ctl_since_reduce = bump_count(ctl_since_reduce);
			ctl_since_raise  = bump_count(ctl_since_raise);
			if (iters > ctl_high_iters) begin
				ctl_since_reduce = '0;
				ctl_last_chance  = 1'b0;
				ctl_step = lower_of((shrunk > ctl_floor) ? shrunk : ctl_floor, ceiling);
			end else if (iters <= ctl_low_iters && ctl_since_reduce > ctl_hold_reduce
					&& ctl_since_raise > ctl_hold_raise && ctl_step < ceiling) begin
				ctl_since_raise = '0;
				ctl_step = lower_of(q16_scale(ctl_step, ctl_raise), ceiling);
			end
		end
		chosen = ctl_step;
	endtask

	// Registers change only once every result has drained from the block.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
		s_tvalid <= 1'b0;
		wait (expected_steps.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_REDUCTION_FACTOR: ctl_reduce      = value[RED_W-1:0];
			REG_RAISE_FACTOR:     ctl_raise       = value[RAISE_W-1:0];
			REG_STEPS_BEFORE_RED: ctl_hold_reduce = value[COUNT_W-1:0];
			REG_STEPS_BEFORE_RSE: ctl_hold_raise  = value[COUNT_W-1:0];
			REG_MIN_ITERS:        ctl_low_iters   = value[ITER_W-1:0];
			REG_MAX_ITERS:        ctl_high_iters  = value[ITER_W-1:0];
			REG_MIN_STEP:         ctl_floor       = value[STEP_W-1:0];
			REG_INITIAL_STEP:     ctl_step        = value[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_item(input logic redo, input logic [ITER_W-1:0] iters,
		input logic [STEP_W-1:0] ceiling);
		logic [STEP_W-1:0] chosen;
		s_tvalid <= 1'b1;
		s_tuser  <= redo;
		s_tdata  <= {ceiling, iters};
		do @(posedge clk); while (!s_tready);
		advance_controller(redo, iters, ceiling, chosen);
		expected_steps.push_back(chosen);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic random_config(input bit extremes, input bit all_regs);
		logic [31:0] vals [8];
		int odds;
		int idx;
		odds = extremes ? 70 : 15;
		vals[REG_REDUCTION_FACTOR] = ($urandom_range(99) < odds) ?
			pick_one(0, 1, 65536, 32'h1FFFF) : $urandom_range(8192, 65535);
		vals[REG_RAISE_FACTOR] = ($urandom_range(99) < odds) ?
			pick_one(65536, 32'hFFFFFF, 32768, $urandom & 32'hFFFFFF) :
			$urandom_range(65536, 32'h30000);
		vals[REG_STEPS_BEFORE_RED] = ($urandom_range(99) < odds) ?
			pick_one(0, 1, 65534, $urandom & 32'hFFFF) : $urandom_range(1, 6);
		vals[REG_STEPS_BEFORE_RSE] = ($urandom_range(99) < odds) ?
			pick_one(0, 1, 65534, $urandom & 32'hFFFF) : $urandom_range(1, 6);
		vals[REG_MIN_ITERS] = ($urandom_range(99) < odds) ?
			pick_one(0, 65535, 1, $urandom & 32'hFFFF) : $urandom_range(0, 12);
		vals[REG_MAX_ITERS] = ($urandom_range(99) < odds) ?
			pick_one(0, 65535, vals[REG_MIN_ITERS], $urandom & 32'hFFFF) :
			(vals[REG_MIN_ITERS] + $urandom_range(0, 20)) & 32'hFFFF;
		vals[REG_INITIAL_STEP] = ($urandom_range(99) < odds) ?
			pick_one(1, 32'hFFFFFFFF, 32'h80000000, $urandom) :
			$urandom_range(1000, 32'h00FFFFFF);
		vals[REG_MIN_STEP] = ($urandom_range(99) < odds) ?
			pick_one(0, 32'hFFFFFFFF, vals[REG_INITIAL_STEP], $urandom) :
			$urandom_range(0, vals[REG_INITIAL_STEP] / 4);
		if (all_regs) begin
			for (int i = REG_REDUCTION_FACTOR; i <= REG_MIN_STEP; i++) begin
				write_reg(IDX_W'(i), vals[i]);
			end
		end else begin
			idx = $urandom_range(REG_REDUCTION_FACTOR, REG_MIN_STEP);
			write_reg(IDX_W'(idx), vals[idx]);
		end
		// The start step goes last so that it also restarts the current step.
		write_reg(REG_INITIAL_STEP, vals[REG_INITIAL_STEP]);
	endtask

	// Iteration counts cluster around the two thresholds; ceilings near the step.
	task automatic random_item();
		logic              redo;
		logic [ITER_W-1:0] iters;
		logic [STEP_W-1:0] ceiling;
		int r;
		redo = ($urandom_range(99) < 35);
		r = $urandom_range(99);
		if (r < 40) begin
			iters = ITER_W'($urandom_range(int'(ctl_low_iters), 0));
		end else if (r < 80) begin
			iters = ITER_W'($urandom_range(int'(ctl_high_iters) + 3, int'(ctl_low_iters)));
		end else begin
			iters = ITER_W'($urandom);
		end
		r = $urandom_range(99);
		if (r < 35) begin
			ceiling = '1;
		end else if (r < 70) begin
			ceiling = ctl_step + STEP_W'($urandom_range(4096)) - STEP_W'(1024);
		end else begin
			ceiling = $urandom;
		end
		send_item(redo, iters, ceiling);
	endtask

	task automatic test_reset_defaults();
		send_item(1'b0, 16'd0, '1);
		send_item(1'b0, 16'd1, '1);
		send_item(1'b0, 16'd0, 32'd100000);
		send_item(1'b0, 16'd0, 32'd100000);
		send_item(1'b0, 16'hFFFF, '1);
		send_item(1'b1, 16'd0, '1);
		send_item(1'b1, 16'd0, 32'd0);
		send_item(1'b1, 16'd0, '1);
		send_item(1'b1, 16'd0, '1);
	endtask

	task automatic test_floor_fallback();
		write_reg(REG_MIN_STEP, 32'd1000);
		write_reg(REG_INITIAL_STEP, 32'd1500);
		send_item(1'b1, 16'd0, 32'd10);
		send_item(1'b1, 16'd0, 32'd10);
		send_item(1'b0, 16'hFFFF, '1);
		send_item(1'b1, 16'd0, 32'd10);
		send_item(1'b1, 16'd7, '1);
	endtask

	task automatic test_factor_extremes();
		write_reg(REG_RAISE_FACTOR, 32'hFFFFFF);
		write_reg(REG_INITIAL_STEP, 32'h80000000);
		send_item(1'b0, 16'd0, '1);
		send_item(1'b0, 16'd0, '1);
		write_reg(REG_REDUCTION_FACTOR, 32'h1FFFF);
		send_item(1'b0, 16'hFFFF, '1);
		write_reg(REG_REDUCTION_FACTOR, 32'd0);
		send_item(1'b1, 16'd0, '1);
		send_item(1'b1, 16'd0, '1);
		write_reg(REG_RAISE_FACTOR, 32'd0);
		write_reg(REG_INITIAL_STEP, 32'd5000);
		send_item(1'b0, 16'd0, '1);
		send_item(1'b0, 16'd0, '1);
		write_reg(REG_RAISE_FACTOR, 32'd32768);
		write_reg(REG_INITIAL_STEP, 32'd5000);
		send_item(1'b0, 16'd1, '1);
		send_item(1'b0, 16'd0, '1);
	endtask

	// A raise becomes possible only once the reduction hold-off has passed.
	task automatic test_hold_off_counters();
		write_reg(REG_REDUCTION_FACTOR, 32'd32768);
		write_reg(REG_RAISE_FACTOR, 32'd65536 + 32'd4096);
		write_reg(REG_STEPS_BEFORE_RED, 32'd8);
		write_reg(REG_STEPS_BEFORE_RSE, 32'd1);
		write_reg(REG_MIN_ITERS, 32'd65535);
		write_reg(REG_MAX_ITERS, 32'd65535);
		write_reg(REG_MIN_STEP, 32'd1);
		write_reg(REG_INITIAL_STEP, 32'd1000);
		for (int n = 0; n < 20; n++) begin
			send_item(1'b0, ITER_W'($urandom),
				($urandom_range(7) == 0) ? STEP_W'($urandom) : '1);
		end
	endtask

	task automatic run_random_phase(input int idle, input int stall, input int items,
		input bit extremes);
		send_idle_pct = idle;
		stall_pct     = stall;
		for (int n = 0; n < items; n++) begin
			if (n % 50 == 0) begin
				random_config(extremes, n == 0);
			end
			random_item();
		end
	endtask

	task automatic test_random_phases();
		run_random_phase(0, 0, 300, 1'b0);
		run_random_phase(78, 0, 300, 1'b0);
		run_random_phase(0, 78, 300, 1'b0);
		run_random_phase(22, 22, 300, 1'b0);
		run_random_phase(22, 22, 300, 1'b1);
	endtask

	// The output stays blocked while items keep coming, so the input must stall.
	task automatic test_input_backpressure();
		send_idle_pct = 0;
		stall_pct     = 0;
		random_config(1'b0, 1'b1);
		@(negedge clk);
		hold_req = 300;
		@(posedge clk);
		for (int n = 0; n < 60; n++) begin
			random_item();
		end
	endtask

	initial begin
		reset_controller_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_floor_fallback();
		test_factor_extremes();
		test_hold_off_counters();
		test_random_phases();
		test_input_backpressure();
		s_tvalid <= 1'b0;
		wait (expected_steps.size() == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
